// ----- sv/ppci_pkg.sv -----
// Package for the planar pose compose/invert block: word types, CORDIC constants,
// and the carried pose data shared by the cells and the back end.
// No dependencies.
`default_nettype none

package ppci_pkg;

    localparam int PPCI_CORDIC_STAGES = 16;
    localparam int PPCI_ATAN_ENTRIES  = 24;

    localparam logic signed [31:0] PPCI_CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [63:0] PPCI_Q30_HALF    = 64'sd536870912;

    // atan(2^-i) in 32-bit binary angle units
    localparam logic signed [31:0] PPCI_ATAN [PPCI_ATAN_ENTRIES] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    localparam logic PPCI_CMD_COMPOSE = 1'b0;
    localparam logic PPCI_CMD_INVERT  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] left_x;
        logic signed [31:0] left_y;
        logic signed [31:0] left_z;
        logic signed [15:0] left_yaw;
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
        logic signed [31:0] right_z;
        logic signed [15:0] right_yaw;
    } ppci_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [15:0] out_yaw;
        logic               saturated;
    } ppci_out_t;

    // CORDIC vector, Q2.30 plus remaining angle
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] ang;
    } ppci_vec_t;

    // operands riding alongside the CORDIC vector
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] op_a;     // right_x on compose, left_x on invert
        logic signed [31:0] op_b;     // right_y on compose, left_y on invert
        logic signed [31:0] base_x;   // left_x on compose, zero on invert
        logic signed [31:0] base_y;
        logic signed [32:0] z_sum;    // unsaturated z result
        logic        [15:0] yaw;      // final yaw, already wrapped
        logic        [1:0]  quad;
    } ppci_carry_t;

endpackage

`default_nettype wire

// ----- sv/planar_pose_compose_invert.sv -----
// Planar pose compose/invert: from accepted start to done a word passes one
// register per CORDIC cell, then the quadrant, product, sum and round/saturate
// registers. Throughput one word per cycle; busy stays low.
// done is a single-cycle strobe with the result word; the receiver cannot stall.
// Reset (rst_n, async, active low) clears every valid bit; data is not reset.
// Depends on ppci_pkg, ppci_cordic_cell, ppci_combine.
`default_nettype none

module planar_pose_compose_invert
    import ppci_pkg::*;
#(
    parameter int CORDIC_STAGES = PPCI_CORDIC_STAGES
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire ppci_in_t operands,
    output logic          done,
    output ppci_out_t     result
);

    localparam int LATENCY = CORDIC_STAGES + 4;

    // Pure feed-forward pipeline: nothing ever holds the input off.
    assign busy = 1'b0;

    logic        accept;
    logic [15:0] yaw_sum;
    logic [15:0] yaw_shift;
    logic [15:0] residue;
    logic [1:0]  quad;
    ppci_vec_t   head_vec;
    ppci_carry_t head_carry;

    assign accept = start & ~busy;

    // Quadrant reduction: q = ((yaw + 8192) >> 14) mod 4, residue in
    // [-8192, 8191] goes into the CORDIC, the quarter turns are applied
    // exactly in the back end.
    assign yaw_shift = operands.left_yaw + 16'd8192;
    assign quad      = yaw_shift[15:14];
    assign residue   = operands.left_yaw - {quad, 14'b0};

    // Final yaw: sum on compose, negation on invert, both mod a full turn.
    always_comb
    begin
        if (operands.cmd == PPCI_CMD_INVERT)
        begin
            yaw_sum = -operands.left_yaw;
        end
        else
        begin
            yaw_sum = operands.left_yaw + operands.right_yaw;
        end
    end

    always_comb
    begin
        head_vec.x   = PPCI_CORDIC_GAIN;
        head_vec.y   = 32'sd0;
        head_vec.ang = {residue, 16'b0};

        head_carry.cmd  = operands.cmd;
        head_carry.yaw  = yaw_sum;
        head_carry.quad = quad;
        if (operands.cmd == PPCI_CMD_INVERT)
        begin
            head_carry.op_a   = operands.left_x;
            head_carry.op_b   = operands.left_y;
            head_carry.base_x = 32'sd0;
            head_carry.base_y = 32'sd0;
            head_carry.z_sum  = -{operands.left_z[31], operands.left_z};
        end
        else
        begin
            head_carry.op_a   = operands.right_x;
            head_carry.op_b   = operands.right_y;
            head_carry.base_x = operands.left_x;
            head_carry.base_y = operands.left_y;
            head_carry.z_sum  = {operands.left_z[31], operands.left_z}
                              + {operands.right_z[31], operands.right_z};
        end
    end

    // CORDIC chain: one cell per micro-rotation, each hands its word on
    // every cycle.
    logic        chain_valid [CORDIC_STAGES + 1];
    ppci_vec_t   chain_vec   [CORDIC_STAGES + 1];
    ppci_carry_t chain_carry [CORDIC_STAGES + 1];

    assign chain_valid[0] = accept;
    assign chain_vec[0]   = head_vec;
    assign chain_carry[0] = head_carry;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        ppci_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .in_carry  (chain_carry[i]),
            .out_valid (chain_valid[i + 1]),
            .out_vec   (chain_vec[i + 1]),
            .out_carry (chain_carry[i + 1])
        );
    end

    // Quadrant fix-up, products, sums, round and saturate.
    ppci_combine u_combine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[CORDIC_STAGES]),
        .in_vec   (chain_vec[CORDIC_STAGES]),
        .in_carry (chain_carry[CORDIC_STAGES]),
        .done     (done),
        .result   (result)
    );

    // Every accepted word comes out on done once it has passed the whole pipeline.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word did not complete on time");

    // No word out on done that was not accepted at the head of the pipeline.
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without matching accepted word");

    // Yaw rides the carry path; checks alignment of carry and result.
    a_yaw_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_yaw == $past(yaw_sum, LATENCY)))
        else $error("result yaw out of step with its input word");

endmodule

`default_nettype wire

// ----- sv/ppci_cordic_cell.sv -----
// One rotation-mode CORDIC cell: a single micro-rotation plus the carried word.
// Depends on ppci_pkg.
`default_nettype none

module ppci_cordic_cell
    import ppci_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire ppci_vec_t   in_vec,
    input  wire ppci_carry_t in_carry,
    output logic             out_valid,
    output ppci_vec_t        out_vec,
    output ppci_carry_t      out_carry
);

    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               valid_reg;
    ppci_vec_t          vec_reg;
    ppci_vec_t          vec_next;
    ppci_carry_t        carry_reg;

    assign x_in = in_vec.x;
    assign y_in = in_vec.y;
    assign dx   = y_in >>> STAGE;
    assign dy   = x_in >>> STAGE;

    always_comb
    begin
        if (!in_vec.ang[31])
        begin
            vec_next.x   = x_in - dx;
            vec_next.y   = y_in + dy;
            vec_next.ang = in_vec.ang - PPCI_ATAN[STAGE];
        end
        else
        begin
            vec_next.x   = x_in + dx;
            vec_next.y   = y_in - dy;
            vec_next.ang = in_vec.ang + PPCI_ATAN[STAGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg   <= vec_next;
        carry_reg <= in_carry;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_carry = carry_reg;

endmodule

`default_nettype wire

// ----- sv/ppci_combine.sv -----
// Back end: quadrant fix-up, four products, sums, rounding and saturation.
// Depends on ppci_pkg.
`default_nettype none

module ppci_combine
    import ppci_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire ppci_vec_t   in_vec,
    input  wire ppci_carry_t in_carry,
    output logic             done,
    output ppci_out_t        result
);

    // quadrant stage
    logic               q_valid_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] c_next;
    logic signed [31:0] s_next;
    ppci_carry_t        q_carry_reg;

    // product stage
    logic               m_valid_reg;
    logic signed [63:0] ac_reg;
    logic signed [63:0] bs_reg;
    logic signed [63:0] bc_reg;
    logic signed [63:0] as_reg;
    ppci_carry_t        m_carry_reg;

    // sum stage
    logic               s_valid_reg;
    logic signed [63:0] px_reg;
    logic signed [63:0] py_reg;
    logic signed [63:0] px_next;
    logic signed [63:0] py_next;
    logic signed [63:0] base_x64;
    logic signed [63:0] base_y64;
    ppci_carry_t        s_carry_reg;

    // round / saturate stage
    logic               r_valid_reg;
    ppci_out_t          result_reg;
    ppci_out_t          result_next;
    logic signed [63:0] rx_shift;
    logic signed [63:0] ry_shift;
    logic               clip_x;
    logic               clip_y;
    logic               clip_z;

    always_comb
    begin
        unique case (in_carry.quad)
            2'd0:
            begin
                c_next = in_vec.x;
                s_next = in_vec.y;
            end
            2'd1:
            begin
                c_next = -in_vec.y;
                s_next = in_vec.x;
            end
            2'd2:
            begin
                c_next = -in_vec.x;
                s_next = -in_vec.y;
            end
            default:
            begin
                c_next = in_vec.y;
                s_next = -in_vec.x;
            end
        endcase
    end

    // compose: x = L + a*c - b*s, y = L + b*c + a*s
    // invert : x = -a*c - b*s,    y = a*s - b*c   (base is zero)
    always_comb
    begin
        base_x64 = {{2{m_carry_reg.base_x[31]}}, m_carry_reg.base_x, 30'b0};
        base_y64 = {{2{m_carry_reg.base_y[31]}}, m_carry_reg.base_y, 30'b0};
        if (m_carry_reg.cmd == PPCI_CMD_INVERT)
        begin
            px_next = base_x64 - ac_reg - bs_reg;
            py_next = base_y64 - bc_reg + as_reg;
        end
        else
        begin
            px_next = base_x64 + ac_reg - bs_reg;
            py_next = base_y64 + bc_reg + as_reg;
        end
    end

    assign rx_shift = (px_reg + PPCI_Q30_HALF) >>> 30;
    assign ry_shift = (py_reg + PPCI_Q30_HALF) >>> 30;

    always_comb
    begin
        clip_x = (rx_shift[63:31] != {33{rx_shift[63]}});
        clip_y = (ry_shift[63:31] != {33{ry_shift[63]}});
        clip_z = (s_carry_reg.z_sum[32] != s_carry_reg.z_sum[31]);

        if (clip_x)
        begin
            result_next.out_x = rx_shift[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            result_next.out_x = rx_shift[31:0];
        end

        if (clip_y)
        begin
            result_next.out_y = ry_shift[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            result_next.out_y = ry_shift[31:0];
        end

        if (clip_z)
        begin
            result_next.out_z = s_carry_reg.z_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            result_next.out_z = s_carry_reg.z_sum[31:0];
        end

        result_next.out_yaw   = s_carry_reg.yaw;
        result_next.saturated = clip_x | clip_y | clip_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= in_valid;
            m_valid_reg <= q_valid_reg;
            s_valid_reg <= m_valid_reg;
            r_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg       <= c_next;
        s_reg       <= s_next;
        q_carry_reg <= in_carry;

        ac_reg      <= q_carry_reg.op_a * c_reg;
        bs_reg      <= q_carry_reg.op_b * s_reg;
        bc_reg      <= q_carry_reg.op_b * c_reg;
        as_reg      <= q_carry_reg.op_a * s_reg;
        m_carry_reg <= q_carry_reg;

        px_reg      <= px_next;
        py_reg      <= py_next;
        s_carry_reg <= m_carry_reg;

        result_reg  <= result_next;
    end

    assign done   = r_valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
